// ===== rtl/r2aa_pkg.sv =====
// Shared types, constants and the arctangent table for the rotation matrix
// to axis-angle converter. No dependencies.
`timescale 1ns / 1ps

package r2aa_pkg;

  // Number of pipelined steps in each iterative unit.
  localparam int SQRT_STEPS = 32;
  localparam int PIPE_STEPS = 31;

  // Working widths of the CORDIC datapath.
  localparam int CX_W = 36;
  localparam int Z_W  = 34;

  localparam logic signed [33:0]    TRACE_MIN   = -34'sd1073741824;
  localparam logic signed [33:0]    TRACE_MAX   = 34'sd3221225472;
  localparam logic signed [33:0]    ONE_T       = 34'sd1073741824;
  localparam logic [30:0]           THRESH_RESET = 31'd10737;
  localparam logic [31:0]           ONE_Q30     = 32'd1073741824;
  localparam logic [30:0]           ONE_Q30_U   = 31'd1073741824;
  localparam logic signed [Z_W-1:0] HALF_PI_Z   = 34'sd1686629713;
  localparam logic signed [Z_W-1:0] ANGLE_MAX_Z = 34'sd3373259421;
  localparam logic [31:0]           ANGLE_MAX   = 32'd3373259421;
  localparam logic [63:0]           ONE_SQ      = 64'h4000_0000_0000_0000;

  // What the front end hands to the back end for one matrix.
  typedef struct packed {
    logic                    ident;
    logic                    zero;
    logic signed [32:0]      cosv;
    logic [2:0]              neg;
    logic [2:0][30:0]        mag;
  } r2aa_work_t;

  // atan(2^-i) in Q2.30.
  function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned i);
    logic signed [Z_W-1:0] a;
    case (i)
      0:       a = 34'sd843314857;
      1:       a = 34'sd497837829;
      2:       a = 34'sd263043837;
      3:       a = 34'sd133525159;
      4:       a = 34'sd67021687;
      5:       a = 34'sd33543516;
      6:       a = 34'sd16775851;
      7:       a = 34'sd8388437;
      8:       a = 34'sd4194283;
      9:       a = 34'sd2097149;
      default: a = 34'sd1 <<< (30 - i);
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/r2aa_in_if.sv =====
// Input channel of the converter: one matrix per beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface r2aa_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

// ===== rtl/r2aa_out_if.sv =====
// Output channel of the converter: one axis-angle result per beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface r2aa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] axis_x, axis_y, axis_z;
  logic [31:0]        angle;
  logic               rotated;

  modport source (output valid, axis_x, axis_y, axis_z, angle, rotated, input ready);
  modport sink (input valid, axis_x, axis_y, axis_z, angle, rotated, output ready);
endinterface

// ===== rtl/r2aa_front.sv =====
// Front end: accepts matrices, clamps the trace, flags the identity case and
// normalises the skew difference vector. Depends on r2aa_pkg and r2aa_in_if.
`timescale 1ns / 1ps

module r2aa_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [30:0]          cfg_wdata,
  r2aa_in_if.sink              in_ch,
  input  logic                 full,
  output logic                 push,
  output r2aa_pkg::r2aa_work_t push_data
);
  import r2aa_pkg::*;

  logic [30:0] threshold;

  logic               f1_valid;
  logic               f1_ident;
  logic signed [32:0] f1_cos;
  logic signed [32:0] f1_v [3];

  logic       f2_valid;
  r2aa_work_t f2_w;

  logic adv1, adv2;

  logic signed [33:0] trace, trace_cl, trace_gap;
  logic signed [32:0] v_c [3];
  logic [32:0]        mag33 [3];
  logic [32:0]        mx;
  logic [32:0]        tmp;
  logic [5:0]         msb;
  r2aa_work_t         w_c;

  assign adv2         = !f2_valid || !full;
  assign adv1         = !f1_valid || adv2;
  assign in_ch.ready  = adv1;
  assign push         = f2_valid && !full;
  assign push_data    = f2_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  always_comb begin
    trace = 34'(in_ch.m00) + 34'(in_ch.m11) + 34'(in_ch.m22);
    if (trace < TRACE_MIN) begin
      trace_cl = TRACE_MIN;
    end else if (trace > TRACE_MAX) begin
      trace_cl = TRACE_MAX;
    end else begin
      trace_cl = trace;
    end
    trace_gap = TRACE_MAX - trace_cl;
    v_c[0] = 33'(in_ch.m21) - 33'(in_ch.m12);
    v_c[1] = 33'(in_ch.m02) - 33'(in_ch.m20);
    v_c[2] = 33'(in_ch.m10) - 33'(in_ch.m01);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (adv1) begin
      f1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      f1_ident <= trace_gap < $signed({3'b000, threshold});
      f1_cos   <= 33'(trace_cl - ONE_T);
      for (int k = 0; k < 3; k++) begin
        f1_v[k] <= v_c[k];
      end
    end
  end

  // Scale all three magnitudes together so that the largest lies in [2^30, 2^31).
  always_comb begin
    mx  = '0;
    msb = '0;
    tmp = '0;
    for (int k = 0; k < 3; k++) begin
      mag33[k] = f1_v[k][32] ? 33'(-f1_v[k]) : 33'(f1_v[k]);
      if (mag33[k] > mx) begin
        mx = mag33[k];
      end
    end
    for (int b = 0; b < 33; b++) begin
      if (mx[b]) begin
        msb = 6'(b);
      end
    end
    w_c.ident = f1_ident;
    w_c.zero  = (mx == '0);
    w_c.cosv  = f1_cos;
    for (int k = 0; k < 3; k++) begin
      w_c.neg[k] = f1_v[k][32];
      if (msb > 6'd30) begin
        tmp = mag33[k] >> (msb - 6'd30);
      end else begin
        tmp = mag33[k] << (6'd30 - msb);
      end
      w_c.mag[k] = tmp[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (adv2) begin
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      f2_w <= w_c;
    end
  end

endmodule

// ===== rtl/r2aa_queue.sv =====
// Short first-in first-out queue between the front end and the back end.
// Depends on r2aa_pkg.
`timescale 1ns / 1ps

module r2aa_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  r2aa_pkg::r2aa_work_t push_data,
  output logic                 full,
  output logic                 valid,
  output r2aa_pkg::r2aa_work_t data,
  input  logic                 pop
);
  import r2aa_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  r2aa_work_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign valid = (count != '0);
  assign data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !valid))
    else $error("queue read while empty");
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (!push && !pop) |=> $stable(count))
    else $error("queue count moved without a beat");
`endif

endmodule

// ===== rtl/r2aa_back.sv =====
// Back end: square roots, CORDIC angle and axis division, all pipelined and
// advancing together whenever the output register can move. Depends on
// r2aa_pkg and r2aa_out_if.
`timescale 1ns / 1ps

module r2aa_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  r2aa_pkg::r2aa_work_t q_data,
  output logic                 q_pop,
  r2aa_out_if.source           out_ch
);
  import r2aa_pkg::*;

  logic adv;

  logic       st0_valid;
  r2aa_work_t st0_w;
  logic       st1_valid;
  r2aa_work_t st1_w;
  logic [63:0] st1_csq;
  logic [61:0] st1_msq [3];

  logic [SQRT_STEPS:0] sq_valid;
  r2aa_work_t          sq_w  [SQRT_STEPS+1];
  logic [63:0]         sq_sv [SQRT_STEPS+1];
  logic [63:0]         sq_sr [SQRT_STEPS+1];
  logic [63:0]         sq_nv [SQRT_STEPS+1];
  logic [63:0]         sq_nr [SQRT_STEPS+1];
  logic [63:0]         sq_sv_next [SQRT_STEPS];
  logic [63:0]         sq_sr_next [SQRT_STEPS];
  logic [63:0]         sq_nv_next [SQRT_STEPS];
  logic [63:0]         sq_nr_next [SQRT_STEPS];

  logic [PIPE_STEPS:0]      cd_valid;
  r2aa_work_t               cd_w [PIPE_STEPS+1];
  logic signed [CX_W-1:0]   cd_x [PIPE_STEPS+1];
  logic signed [CX_W-1:0]   cd_y [PIPE_STEPS+1];
  logic signed [Z_W-1:0]    cd_z [PIPE_STEPS+1];
  logic [31:0]              dv_n [PIPE_STEPS+1];
  logic [2:0][61:0]         dv_rem [PIPE_STEPS+1];
  logic [2:0][30:0]         dv_q [PIPE_STEPS+1];
  logic signed [CX_W-1:0]   cd_x_next [PIPE_STEPS+1];
  logic signed [CX_W-1:0]   cd_y_next [PIPE_STEPS+1];
  logic signed [Z_W-1:0]    cd_z_next [PIPE_STEPS+1];
  logic [2:0][61:0]         dv_rem_next [PIPE_STEPS+1];
  logic [2:0][30:0]         dv_q_next [PIPE_STEPS+1];

  logic               out_valid;
  logic signed [31:0] out_x, out_y, out_z;
  logic [31:0]        out_angle;
  logic               out_rot;

  logic [32:0]        cabs;
  logic [63:0]        csq_c;
  logic [61:0]        msq_c [3];
  logic [31:0]        s_val, n_val;
  logic signed [32:0] c_end;
  logic [61:0]        dsh;
  logic signed [Z_W-1:0] z_end;
  logic [31:0]        ang_c;
  logic [30:0]        q_sat;
  logic signed [31:0] ax_c [3];

  assign adv   = !out_valid || out_ch.ready;
  assign q_pop = adv && q_valid;

  assign out_ch.valid   = out_valid;
  assign out_ch.axis_x  = out_x;
  assign out_ch.axis_y  = out_y;
  assign out_ch.axis_z  = out_z;
  assign out_ch.angle   = out_angle;
  assign out_ch.rotated = out_rot;

  // Squares for both square roots.
  always_comb begin
    cabs  = st0_w.cosv[32] ? 33'(-st0_w.cosv) : 33'(st0_w.cosv);
    csq_c = cabs[31:0] * cabs[31:0];
    for (int k = 0; k < 3; k++) begin
      msq_c[k] = st0_w.mag[k] * st0_w.mag[k];
    end
  end

  // Digit-by-digit square root, one result bit per stage.
  always_comb begin
    logic [63:0] bitv;
    logic [64:0] ts, tn;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      bitv = 64'd1 << (2 * (SQRT_STEPS - 1 - k));
      ts = {1'b0, sq_sr[k]} + {1'b0, bitv};
      tn = {1'b0, sq_nr[k]} + {1'b0, bitv};
      if ({1'b0, sq_sv[k]} >= ts) begin
        sq_sv_next[k] = sq_sv[k] - ts[63:0];
        sq_sr_next[k] = (sq_sr[k] >> 1) + bitv;
      end else begin
        sq_sv_next[k] = sq_sv[k];
        sq_sr_next[k] = sq_sr[k] >> 1;
      end
      if ({1'b0, sq_nv[k]} >= tn) begin
        sq_nv_next[k] = sq_nv[k] - tn[63:0];
        sq_nr_next[k] = (sq_nr[k] >> 1) + bitv;
      end else begin
        sq_nv_next[k] = sq_nv[k];
        sq_nr_next[k] = sq_nr[k] >> 1;
      end
    end
  end

  // Entry to the CORDIC and divider pipelines, then one step per stage. A
  // negative cosine is turned by a quarter turn first so that the vectoring
  // starts in the right half.
  always_comb begin
    s_val = sq_sr[SQRT_STEPS][31:0];
    n_val = sq_nr[SQRT_STEPS][31:0];
    c_end = sq_w[SQRT_STEPS].cosv;
    if (c_end < 0) begin
      cd_x_next[0] = CX_W'({1'b0, s_val});
      cd_y_next[0] = -CX_W'(c_end);
      cd_z_next[0] = HALF_PI_Z;
    end else begin
      cd_x_next[0] = CX_W'(c_end);
      cd_y_next[0] = CX_W'({1'b0, s_val});
      cd_z_next[0] = '0;
    end
    for (int k = 0; k < 3; k++) begin
      dv_rem_next[0][k] = 62'({sq_w[SQRT_STEPS].mag[k], 30'b0}) + 62'(n_val[31:1]);
    end
    dv_q_next[0] = '0;
    dsh = '0;
    for (int i = 0; i < PIPE_STEPS; i++) begin
      if (cd_y[i] > 0) begin
        cd_x_next[i+1] = cd_x[i] + (cd_y[i] >>> i);
        cd_y_next[i+1] = cd_y[i] - (cd_x[i] >>> i);
        cd_z_next[i+1] = cd_z[i] + atan_q30(i);
      end else begin
        cd_x_next[i+1] = cd_x[i] - (cd_y[i] >>> i);
        cd_y_next[i+1] = cd_y[i] + (cd_x[i] >>> i);
        cd_z_next[i+1] = cd_z[i] - atan_q30(i);
      end
      dsh = 62'(dv_n[i]) << (PIPE_STEPS - 1 - i);
      for (int k = 0; k < 3; k++) begin
        if (dv_rem[i][k] >= dsh) begin
          dv_rem_next[i+1][k] = dv_rem[i][k] - dsh;
          dv_q_next[i+1][k]   = {dv_q[i][k][29:0], 1'b1};
        end else begin
          dv_rem_next[i+1][k] = dv_rem[i][k];
          dv_q_next[i+1][k]   = {dv_q[i][k][29:0], 1'b0};
        end
      end
    end
  end

  // Output formatting: clamp, saturate, apply signs and special cases.
  always_comb begin
    z_end = cd_z[PIPE_STEPS];
    if (z_end < 0) begin
      ang_c = '0;
    end else if (z_end > ANGLE_MAX_Z) begin
      ang_c = ANGLE_MAX;
    end else begin
      ang_c = z_end[31:0];
    end
    q_sat = '0;
    for (int k = 0; k < 3; k++) begin
      q_sat = (dv_q[PIPE_STEPS][k] > ONE_Q30_U) ? ONE_Q30_U : dv_q[PIPE_STEPS][k];
      if (cd_w[PIPE_STEPS].zero) begin
        ax_c[k] = '0;
      end else if (cd_w[PIPE_STEPS].neg[k]) begin
        ax_c[k] = -$signed({1'b0, q_sat});
      end else begin
        ax_c[k] = $signed({1'b0, q_sat});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st0_valid <= 1'b0;
      st1_valid <= 1'b0;
      sq_valid  <= '0;
      cd_valid  <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      st0_valid <= q_valid;
      st1_valid <= st0_valid;
      sq_valid  <= {sq_valid[SQRT_STEPS-1:0], st1_valid};
      cd_valid  <= {cd_valid[PIPE_STEPS-1:0], sq_valid[SQRT_STEPS]};
      out_valid <= cd_valid[PIPE_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st0_w   <= q_data;
      st1_w   <= st0_w;
      st1_csq <= csq_c;
      for (int k = 0; k < 3; k++) begin
        st1_msq[k] <= msq_c[k];
      end
      sq_w[0]  <= st1_w;
      sq_sv[0] <= ONE_SQ - st1_csq;
      sq_sr[0] <= '0;
      sq_nv[0] <= 64'(st1_msq[0]) + 64'(st1_msq[1]) + 64'(st1_msq[2]);
      sq_nr[0] <= '0;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        sq_w[k+1]  <= sq_w[k];
        sq_sv[k+1] <= sq_sv_next[k];
        sq_sr[k+1] <= sq_sr_next[k];
        sq_nv[k+1] <= sq_nv_next[k];
        sq_nr[k+1] <= sq_nr_next[k];
      end
      cd_w[0] <= sq_w[SQRT_STEPS];
      dv_n[0] <= n_val;
      for (int i = 0; i < PIPE_STEPS; i++) begin
        cd_w[i+1] <= cd_w[i];
        dv_n[i+1] <= dv_n[i];
      end
      for (int i = 0; i <= PIPE_STEPS; i++) begin
        cd_x[i]   <= cd_x_next[i];
        cd_y[i]   <= cd_y_next[i];
        cd_z[i]   <= cd_z_next[i];
        dv_rem[i] <= dv_rem_next[i];
        dv_q[i]   <= dv_q_next[i];
      end
      if (cd_w[PIPE_STEPS].ident) begin
        out_x     <= '0;
        out_y     <= '0;
        out_z     <= $signed(ONE_Q30);
        out_angle <= '0;
        out_rot   <= 1'b0;
      end else begin
        out_x     <= ax_c[0];
        out_y     <= ax_c[1];
        out_z     <= ax_c[2];
        out_angle <= ang_c;
        out_rot   <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_ident_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_rot) |->
      (out_angle == '0 && out_x == '0 && out_y == '0 && out_z == $signed(ONE_Q30)))
    else $error("identity beat with wrong payload");
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_angle <= ANGLE_MAX))
    else $error("angle beyond pi");
  a_pop_enters: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> st0_valid)
    else $error("popped item did not enter the pipeline");
`endif

endmodule

// ===== rtl/rotation_matrix_to_axis_angle.sv =====
// Top level of the rotation matrix to axis-angle converter.
// Depends on r2aa_pkg, r2aa_in_if, r2aa_out_if, r2aa_front, r2aa_queue, r2aa_back.
`timescale 1ns / 1ps

// One matrix is taken per beat and one result leaves per beat, so a steady
// stream runs at one item per clock while the output is not stalled. On its
// way from acceptance to the output, a beat passes two front-end stages, one
// queue entry and 68 back-end stages, the first of them loaded at the
// accepting edge; the 32-step square roots and the 31-step CORDIC and dividers
// set the depth. The queue of QUEUE_DEPTH entries lets the front keep
// accepting while the output is stalled.
module rotation_matrix_to_axis_angle #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata,
  r2aa_in_if.sink     in_ch,
  r2aa_out_if.source  out_ch
);
  import r2aa_pkg::*;

  logic       push, full, q_valid, q_pop;
  r2aa_work_t push_data, q_data;

  r2aa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  r2aa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .valid     (q_valid),
    .data      (q_data),
    .pop       (q_pop)
  );

  r2aa_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== dv/rotation_matrix_to_axis_angle_test.sv =====
// Self-checking testbench for the rotation matrix to axis-angle converter:
// a table of directed matrices, then random matrices checked by a predictor.
// Depends on r2aa_pkg, r2aa_in_if, r2aa_out_if and rotation_matrix_to_axis_angle.
`timescale 1ns / 1ps

module rotation_matrix_to_axis_angle_test;
  import r2aa_pkg::*;

  typedef struct packed {
    logic signed [31:0] x, y, z;
    logic [31:0]        ang;
    logic               rot;
  } pose_t;

  typedef struct {
    logic signed [31:0] m [9];
    bit                 typed;
    pose_t              res;
  } stim_row_t;

  localparam int LONG_HOLD = 400;
  localparam int CYCLE_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [30:0] cfg_wdata = '0;

  r2aa_in_if  in_ch ();
  r2aa_out_if out_ch ();

  rotation_matrix_to_axis_angle dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  logic [30:0] thresh;
  pose_t       pending [$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          hold_off = 1'b0;
  bit          sending_done = 1'b0;

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint atan_step(input int i);
    longint t [10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                       33543516, 16775851, 8388437, 4194283, 2097149};
    return i < 10 ? t[i] : (longint'(1) << (30 - i));
  endfunction

  // Vectoring CORDIC; >>> on longint is an arithmetic (floor) shift.
  function automatic longint cordic_angle(input longint c, input longint s);
    longint x, y, z, nx, ny;
    x = c; y = s; z = 0;
    if (x < 0) begin
      x = s; y = -c; z = 1686629713;
    end
    for (int i = 0; i <= 30; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_step(i);
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_step(i);
      end
      x = nx; y = ny;
    end
    if (z < 0) z = 0;
    if (z > 64'sd3373259421) z = 64'sd3373259421;
    return z;
  endfunction

  function automatic pose_t predict_pose(input logic signed [31:0] m [9]);
    pose_t  p;
    longint t, c, v [3], mx, n, q;
    logic [63:0] mag [3], sum;
    t = longint'(m[0]) + longint'(m[4]) + longint'(m[8]);
    if (t < -64'sd1073741824) t = -64'sd1073741824;
    if (t > 64'sd3221225472) t = 64'sd3221225472;
    if (64'sd3221225472 - t < longint'({33'd0, thresh})) begin
      p = '{x: 0, y: 0, z: 32'sd1073741824, ang: 0, rot: 1'b0};
      return p;
    end
    c = t - 64'sd1073741824;
    p.ang = 32'(cordic_angle(c, longint'(isqrt((64'd1 << 62) - 64'(c * c)))));
    p.rot = 1'b1;
    v[0] = longint'(m[7]) - m[5];
    v[1] = longint'(m[2]) - m[6];
    v[2] = longint'(m[3]) - m[1];
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = v[k] < 0 ? -v[k] : v[k];
      if (mag[k] > mx) mx = mag[k];
    end
    if (mx == 0) begin
      p.x = 0; p.y = 0; p.z = 0;
      return p;
    end
    while (mx >= (longint'(1) << 31)) begin
      for (int k = 0; k < 3; k++) mag[k] = mag[k] >> 1;
      mx = mx >> 1;
    end
    while (mx < (longint'(1) << 30)) begin
      for (int k = 0; k < 3; k++) mag[k] = mag[k] << 1;
      mx = mx << 1;
    end
    sum = 0;
    for (int k = 0; k < 3; k++) sum += mag[k] * mag[k];
    n = isqrt(sum);
    for (int k = 0; k < 3; k++) begin
      q = ((mag[k] << 30) + (n >> 1)) / n;
      if (q > 64'sd1073741824) q = 64'sd1073741824;
      mag[k] = v[k] < 0 ? -q : q;
    end
    p.x = mag[0][31:0]; p.y = mag[1][31:0]; p.z = mag[2][31:0];
    return p;
  endfunction

  task automatic note_mismatch(input string what, input longint e, input longint a);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, e, a);
  endtask

  // Result side: random stalls, plus a long hold-off requested by the sender.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending.size() == 0) begin
        note_mismatch("unexpected beat", 0, 1);
      end else begin
        pose_t e;
        e = pending.pop_front();
        if (e.x !== out_ch.axis_x) note_mismatch("axis_x", e.x, out_ch.axis_x);
        if (e.y !== out_ch.axis_y) note_mismatch("axis_y", e.y, out_ch.axis_y);
        if (e.z !== out_ch.axis_z) note_mismatch("axis_z", e.z, out_ch.axis_z);
        if (e.ang !== out_ch.angle) note_mismatch("angle", e.ang, out_ch.angle);
        if (e.rot !== out_ch.rotated) note_mismatch("rotated", e.rot, out_ch.rotated);
      end
    end
  end

  int hold_left = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_off && hold_left == 0) hold_left = LONG_HOLD;
    if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) hold_off <= 1'b0;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      if (!sending_done && $urandom_range(0, 7) == 0)
        stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                                   : $urandom_range(1, 3);
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("rotation_matrix_to_axis_angle test failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_entry();
    case ($urandom_range(0, 9))
      0: return 32'sd1073741824;
      1: return -32'sd1073741824;
      2: return $urandom();
      3: return 0;
      default: return $signed($urandom_range(0, 32'd2147483648)) - 32'sd1073741824;
    endcase
  endfunction

  // Trace close to three, so that the identity test is exercised near the threshold.
  function automatic void near_identity(ref logic signed [31:0] m [9]);
    for (int k = 0; k < 9; k++) m[k] = $signed($urandom_range(0, 4000)) - 2000;
    m[0] = 32'sd1073741824 - $urandom_range(0, 20000);
    m[4] = 32'sd1073741824 - $urandom_range(0, 20000);
    m[8] = 32'sd1073741824 - $urandom_range(0, 20000);
  endfunction

  task automatic send_matrix(input logic signed [31:0] m [9], input pose_t e);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 19) == 0) ?
          $urandom_range(8, 40) : $urandom_range(1, 3)) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.m00, in_ch.m01, in_ch.m02} <= {m[0], m[1], m[2]};
    {in_ch.m10, in_ch.m11, in_ch.m12} <= {m[3], m[4], m[5]};
    {in_ch.m20, in_ch.m21, in_ch.m22} <= {m[6], m[7], m[8]};
    do @(posedge clk); while (!in_ch.ready);
    pending.push_back(e);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_thresh(input logic [30:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    thresh = value;
  endtask

  localparam logic signed [31:0] P1 = 32'sd1073741824;
  localparam logic signed [31:0] N1 = -32'sd1073741824;
  pose_t ident_res = '{x: 0, y: 0, z: 32'sd1073741824, ang: 0, rot: 1'b0};

  initial begin
    stim_row_t rows [$];
    stim_row_t r;
    logic signed [31:0] m [9];
    logic [30:0] settings [4] = '{31'd0, 31'd1073741824, 31'd10737, 31'h7FFFFFFF};
    in_ch.valid = 1'b0;
    {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11} = '0;
    {in_ch.m12, in_ch.m20, in_ch.m21, in_ch.m22} = '0;
    thresh = THRESH_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Identity, half turns about each axis, quarter turns, all-extreme entries.
    rows.push_back('{'{P1, 0, 0, 0, P1, 0, 0, 0, P1}, 1, ident_res});
    rows.push_back('{'{P1, 0, 0, 0, N1, 0, 0, 0, N1}, 0, ident_res});
    rows.push_back('{'{N1, 0, 0, 0, P1, 0, 0, 0, N1}, 0, ident_res});
    rows.push_back('{'{N1, 0, 0, 0, N1, 0, 0, 0, P1}, 0, ident_res});
    rows.push_back('{'{N1, N1, N1, N1, N1, N1, N1, N1, N1}, 0, ident_res});
    rows.push_back('{'{0, N1, 0, P1, 0, 0, 0, 0, P1}, 0, ident_res});
    rows.push_back('{'{P1, 0, 0, 0, 0, N1, 0, P1, 0}, 0, ident_res});
    rows.push_back('{'{0, 0, P1, 0, P1, 0, N1, 0, 0}, 0, ident_res});
    rows.push_back('{'{P1, P1, P1, P1, P1, P1, P1, P1, P1}, 0, ident_res});
    rows.push_back('{'{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                       32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                       32'sh7FFFFFFF}, 0, ident_res});
    rows.push_back('{'{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                       32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                       32'sh80000000}, 0, ident_res});
    rows.push_back('{'{P1, 1, 0, -1, P1, 0, 0, 0, P1 - 32'sd10737}, 0, ident_res});
    rows.push_back('{'{P1, 1, 0, -1, P1, 0, 0, 0, P1 - 32'sd10736}, 0, ident_res});
    rows.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 0, ident_res});
    foreach (rows[i]) begin
      send_matrix(rows[i].m, rows[i].typed ? rows[i].res : predict_pose(rows[i].m));
    end
    drain();

    // Threshold zero makes a true identity count as a rotation.
    write_thresh(31'd0);
    r = rows[0];
    send_matrix(r.m, predict_pose(r.m));
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      if (phase > 0) write_thresh(settings[phase - 1]);
      for (int i = 0; i < 240; i++) begin
        if (phase == 2 && i == 50) hold_off = 1'b1;
        if ($urandom_range(0, 3) == 0) near_identity(m);
        else foreach (m[k]) m[k] = rand_entry();
        send_matrix(m, predict_pose(m));
      end
      drain();
    end

    sending_done = 1'b1;
    if (mismatches == 0) begin
      $display("rotation_matrix_to_axis_angle test passed");
    end else begin
      $display("rotation_matrix_to_axis_angle test failed");
    end
    $finish;
  end

endmodule
